FILE: rtl/tdq_pkg.sv
// Shared types and constants of the timestamp delay queue.
package tdq_pkg;

    localparam int HANDLE_W = 16;
    localparam int TS_W     = 64;
    localparam int DELAY_W  = 45;

    // A timestamp more than one second after the previous one counts as a jump.
    localparam logic [TS_W-1:0] NS_PER_SECOND = 64'd1_000_000_000;

    typedef struct packed {
        logic [HANDLE_W-1:0] frame_handle;
        logic [TS_W-1:0]     timestamp_ns;
    } t_in_beat;

    typedef struct packed {
        logic [HANDLE_W-1:0] out_handle;
        logic [TS_W-1:0]     out_timestamp_ns;
        logic                forced_out;
    } t_out_beat;

    // One queued frame as held in the store.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [TS_W-1:0]     ts;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

FILE: rtl/tdq_stream_if.sv
// Valid/ready stream interfaces for the input and result beats.
interface tdq_in_if;
    import tdq_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tdq_out_if;
    import tdq_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/timestamp_delay_queue.sv
// Timestamp delay queue: holds frame handles back until the wanted delay has built up.
// A beat sits in the input register, then its result sits in the output register.
// Throughput: one beat per cycle unless the output stalls, which holds the beat in the
// input register; the queue takes one push and at most one pop per cycle.
// Reset (synchronous, active low) empties the queue, clears the delay to zero and arms a
// flush for the first beat; the store itself is not cleared and needs no clearing pass.
module timestamp_delay_queue #(
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [tdq_pkg::DELAY_W-1:0] i_cfg_wr_data,
    tdq_in_if.sink                   i_in,
    tdq_out_if.source                o_out
);
    import tdq_pkg::*;

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(QUEUE_DEPTH);

    // Circular increment of a store index.
    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == LAST_IDX) ? '0 : idx + 1'b1;
    endfunction

    // Input register: the beat being worked on this cycle.
    logic                 r_in_valid;
    t_entry               r_in_entry;

    // Queue bookkeeping. The oldest frame is kept in r_head_entry so that it can be
    // compared and released without waiting on the store's registered read.
    logic [IDX_W-1:0]     r_head,  n_head;
    logic [CNT_W-1:0]     r_fill,  n_fill;
    t_entry               r_head_entry, n_head_entry;
    logic [TS_W-1:0]      r_prev_time, n_prev_time;
    logic                 r_delay_met, n_delay_met;
    logic                 r_flush_pending, n_flush_pending;
    logic [DELAY_W-1:0]   r_delay;

    // Result register.
    logic                 r_out_valid, n_out_valid;
    t_out_beat            r_out_data,  n_out_data;

    // Forwarding of a write that lands on the slot being read at the same edge.
    logic                 r_byp_valid;
    t_entry               r_byp_data;

    logic                 go;
    logic [TS_W-1:0]      prev_gap;
    logic                 jump;
    logic                 flush;
    logic [CNT_W-1:0]     fill_eff;
    logic [IDX_W-1:0]     head_eff;
    logic                 met_eff;
    logic                 full;
    logic [SUM_W-1:0]     push_sum;
    logic [IDX_W-1:0]     push_idx;
    logic [TS_W-1:0]      age;
    logic                 hold;
    t_entry               second;
    logic [ENTRY_W-1:0]   ram_rd_data;
    logic [IDX_W-1:0]     rd_addr;

    // The work stage advances whenever the result register is free or being drained.
    assign go         = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || go;

    // The second-oldest frame: either fresh from the store or forwarded from a write
    // that hit the same slot at the edge when the read was issued.
    assign second = r_byp_valid ? r_byp_data : t_entry'(ram_rd_data);

    // A timestamp going backwards, or leaping by more than a second, restarts the queue.
    assign prev_gap = r_in_entry.ts - r_prev_time;
    assign jump     = (r_in_entry.ts < r_prev_time) || (prev_gap > NS_PER_SECOND);
    assign flush    = r_flush_pending || jump;

    assign fill_eff = flush ? '0 : r_fill;
    assign head_eff = flush ? '0 : r_head;
    assign met_eff  = flush ? 1'b0 : r_delay_met;
    assign full     = (fill_eff == FULL_CNT);

    // The new frame goes behind the last queued one; with a full queue that is the
    // head's own slot, which is freed by the forced release in the same cycle.
    assign push_sum = SUM_W'(head_eff) + SUM_W'(fill_eff);
    assign push_idx = (push_sum >= DEPTH_S) ? IDX_W'(push_sum - DEPTH_S) : IDX_W'(push_sum);

    // Span of time held in the queue once the new frame is in; an empty queue means
    // the new frame is also the oldest one.
    assign age  = (fill_eff == '0) ? '0 : r_in_entry.ts - r_head_entry.ts;
    assign hold = !met_eff && (age < TS_W'(r_delay));

    always_comb begin
        n_head          = r_head;
        n_fill          = r_fill;
        n_head_entry    = r_head_entry;
        n_prev_time     = r_prev_time;
        n_delay_met     = r_delay_met;
        n_flush_pending = r_flush_pending;
        n_out_valid     = r_out_valid && !o_out.ready;
        n_out_data      = r_out_data;

        if (go) begin
            n_prev_time     = r_in_entry.ts;
            n_flush_pending = 1'b0;
            if (full) begin
                // Queue full: the oldest frame is pushed out early.
                n_out_valid                 = 1'b1;
                n_out_data.out_handle       = r_head_entry.handle;
                n_out_data.out_timestamp_ns = r_head_entry.ts;
                n_out_data.forced_out       = 1'b1;
                n_head                      = idx_inc(head_eff);
                n_head_entry                = second;
                n_fill                      = fill_eff;
                n_delay_met                 = met_eff;
            end else if (hold) begin
                // Still building up the delay: queue the frame and release nothing.
                n_head      = head_eff;
                n_fill      = fill_eff + 1'b1;
                n_delay_met = met_eff;
                if (fill_eff == '0) begin
                    n_head_entry = r_in_entry;
                end
            end else begin
                // Delay reached: queue the frame and release the oldest one.
                n_out_valid           = 1'b1;
                n_out_data.forced_out = 1'b0;
                if (fill_eff == '0) begin
                    n_out_data.out_handle       = r_in_entry.handle;
                    n_out_data.out_timestamp_ns = r_in_entry.ts;
                end else begin
                    n_out_data.out_handle       = r_head_entry.handle;
                    n_out_data.out_timestamp_ns = r_head_entry.ts;
                end
                n_head      = idx_inc(head_eff);
                n_fill      = fill_eff;
                n_delay_met = 1'b1;
                // With at most one frame queued before, the new frame becomes the head.
                n_head_entry = (fill_eff <= CNT_W'(1)) ? r_in_entry : second;
            end
        end

        // A write of the delay restarts the queue on the next beat.
        if (i_cfg_wr_en) begin
            n_flush_pending = 1'b1;
            n_delay_met     = 1'b0;
        end
    end

    // Keep the slot after the next head on the read port at all times.
    assign rd_addr = idx_inc(n_head);

    tdq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (go),
        .i_wr_addr (push_idx),
        .i_wr_data (ENTRY_W'(r_in_entry)),
        .i_rd_addr (rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_head          <= '0;
            r_fill          <= '0;
            r_prev_time     <= '0;
            r_delay_met     <= 1'b0;
            r_flush_pending <= 1'b1;
            r_delay         <= '0;
            r_byp_valid     <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            r_out_valid     <= n_out_valid;
            r_head          <= n_head;
            r_fill          <= n_fill;
            r_prev_time     <= n_prev_time;
            r_delay_met     <= n_delay_met;
            r_flush_pending <= n_flush_pending;
            if (i_cfg_wr_en) begin
                r_delay <= i_cfg_wr_data;
            end
            r_byp_valid <= go && (push_idx == rd_addr);
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_entry.handle <= i_in.data.frame_handle;
            r_in_entry.ts     <= i_in.data.timestamp_ns;
        end
        r_head_entry <= n_head_entry;
        r_out_data   <= n_out_data;
        r_byp_data   <= r_in_entry;
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

FILE: rtl/tdq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module tdq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
